>>> hdl/lew_pkg.sv
// package: shared types and constants of the line editor
package lew_pkg;

  localparam logic [7:0] CH_DEL   = 8'h7f;
  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_KILL  = 8'h15;
  localparam logic [7:0] CH_WERASE = 8'h17;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_EOT   = 8'h04;
  localparam logic [7:0] CH_BEL   = 8'h07;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TILDE = 8'h7e;

  localparam logic [2:0] K_ECHO    = 3'd0;
  localparam logic [2:0] K_NEWLINE = 3'd1;
  localparam logic [2:0] K_BELL    = 3'd2;
  localparam logic [2:0] K_ERASE   = 3'd3;
  localparam logic [2:0] K_ENDED   = 3'd4;

  typedef enum logic [2:0] {
    OP_ERASE,
    OP_KILL,
    OP_WERASE,
    OP_NEWLINE,
    OP_EOT,
    OP_BELL,
    OP_PRINT
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] ch;
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WSPACE,
    ST_WWORD,
    ST_SCAN,
    ST_NL,
    ST_ECHO,
    ST_DONE
  } state_t;

endpackage

>>> hdl/lew_front.sv
// front end: input beats classified into commands, with a short queue
module lew_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        in_byte,
  output logic              cmd_valid,
  input  logic              cmd_ready,
  output lew_pkg::cmd_t     cmd
);
  import lew_pkg::*;

  cmd_t       q [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;
  cmd_t       c_in;
  logic       push, pop;

  always_comb begin
    c_in.ch = in_byte;
    priority if (in_byte == CH_DEL || in_byte == CH_BS) c_in.op = OP_ERASE;
    else if (in_byte == CH_KILL)                         c_in.op = OP_KILL;
    else if (in_byte == CH_WERASE)                       c_in.op = OP_WERASE;
    else if (in_byte == CH_LF || in_byte == CH_CR)       c_in.op = OP_NEWLINE;
    else if (in_byte == CH_EOT)                          c_in.op = OP_EOT;
    else if (in_byte >= CH_SPACE && in_byte <= CH_TILDE) c_in.op = OP_PRINT;
    else                                                 c_in.op = OP_BELL;
  end

  assign in_ready  = (count != 2'd2);
  assign cmd_valid = (count != 2'd0);
  assign cmd       = q[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = cmd_valid && cmd_ready;

  always_ff @(posedge clk) begin
    if (push) q[wr_ptr] <= c_in;
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule

>>> hdl/lew_back.sv
// back end: line store, sequencer and result register
module lew_back #(
  parameter int LINE_WIDTH = 40
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          cmd_valid,
  output logic          cmd_ready,
  input  lew_pkg::cmd_t cmd,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [2:0]    out_kind,
  output logic [7:0]    out_byte,
  output logic [5:0]    erase_count,
  output logic          out_last
);
  import lew_pkg::*;

  localparam int DEPTH = LINE_WIDTH + 1;
  localparam logic [5:0] LW = 6'(LINE_WIDTH);

  logic [7:0] line_store [DEPTH];
  logic [5:0] line_length, line_length_next;
  logic       session_done, session_done_next;
  state_t     state, state_next;
  logic [5:0] ptr, ptr_next;      // scan / echo position
  logic [5:0] removed, removed_next;
  logic [5:0] start, start_next;

  // result register
  logic       emit;
  logic [2:0] e_kind;
  logic [7:0] e_byte;
  logic [5:0] e_cnt;
  logic       e_last;
  logic       free;

  // store write port
  logic       st_we;
  logic [5:0] st_addr;
  logic [7:0] st_data;
  // store read port, registered: entry below ptr while scanning, entry at ptr while echoing
  logic [5:0] rd_addr;
  logic [7:0] rd_data;

  assign free      = !out_valid || out_ready;
  assign cmd_ready = (state == ST_IDLE) && free;

  always_comb begin
    state_next        = state;
    line_length_next  = line_length;
    session_done_next = session_done;
    ptr_next          = ptr;
    removed_next      = removed;
    start_next        = start;
    emit   = 1'b0;
    e_kind = K_BELL;
    e_byte = 8'd0;
    e_cnt  = 6'd0;
    e_last = 1'b1;
    st_we   = 1'b0;
    st_addr = line_length;
    st_data = cmd.ch;
    unique case (state)
      ST_IDLE: begin
        if (cmd_valid && free && !session_done) begin
          unique case (cmd.op)
            OP_ERASE: begin
              emit = 1'b1;
              if (line_length != 6'd0) begin
                line_length_next = line_length - 6'd1;
                e_kind = K_ERASE;
                e_cnt  = 6'd1;
              end
            end
            OP_KILL: begin
              if (line_length != 6'd0) begin
                emit   = 1'b1;
                e_kind = K_ERASE;
                e_cnt  = line_length;
              end
              line_length_next = 6'd0;
            end
            OP_WERASE: begin
              ptr_next     = line_length;
              removed_next = 6'd0;
              state_next   = ST_WSPACE;
            end
            OP_NEWLINE: begin
              emit   = 1'b1;
              e_kind = K_NEWLINE;
              line_length_next = 6'd0;
            end
            OP_EOT: begin
              if (line_length == 6'd0) begin
                emit   = 1'b1;
                e_kind = K_ENDED;
                session_done_next = 1'b1;
              end
            end
            OP_BELL: emit = 1'b1;
            OP_PRINT: begin
              st_we  = 1'b1;
              emit   = 1'b1;
              e_kind = K_ECHO;
              e_byte = cmd.ch;
              line_length_next = line_length + 6'd1;
              if (line_length == LW) begin
                e_last     = 1'b0;
                ptr_next   = LW;
                start_next = LW;
                state_next = ST_SCAN;
              end
            end
            default: emit = 1'b1;
          endcase
        end
      end
      ST_WSPACE: begin
        if (ptr != 6'd0 && rd_data == CH_SPACE) begin
          ptr_next     = ptr - 6'd1;
          removed_next = removed + 6'd1;
        end else state_next = ST_WWORD;
      end
      ST_WWORD: begin
        if (ptr != 6'd0 && rd_data != CH_SPACE) begin
          ptr_next     = ptr - 6'd1;
          removed_next = removed + 6'd1;
        end else if (free) begin
          line_length_next = ptr;
          state_next       = ST_IDLE;
          if (removed != 6'd0) begin
            emit   = 1'b1;
            e_kind = K_ERASE;
            e_cnt  = removed;
          end
        end
      end
      ST_SCAN: begin
        if (ptr != 6'd0 && rd_data == CH_SPACE) begin
          start_next = ptr;
          state_next = ST_NL;
        end else if (ptr == 6'd0) state_next = ST_NL;
        else ptr_next = ptr - 6'd1;
      end
      ST_NL: begin
        if (free) begin
          emit   = 1'b1;
          e_kind = K_NEWLINE;
          e_last = 1'b0;
          ptr_next   = start;
          state_next = ST_ECHO;
        end
      end
      ST_ECHO: begin
        // echo the word and move it down, one character a cycle while the output register is free
        if (free) begin
          emit    = 1'b1;
          e_kind  = K_ECHO;
          e_byte  = rd_data;
          e_last  = (ptr == LW);
          st_we   = 1'b1;
          st_addr = ptr - start;
          st_data = rd_data;
          ptr_next = ptr + 6'd1;
          if (ptr == LW) begin
            line_length_next = LW + 6'd1 - start;
            state_next       = ST_IDLE;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // read address follows the next position so the registered data is ready in the cycle after
  always_comb begin
    if (state_next == ST_ECHO) rd_addr = ptr_next;
    else if (ptr_next == 6'd0) rd_addr = 6'd0;
    else rd_addr = ptr_next - 6'd1;
  end

  always_ff @(posedge clk) begin
    if (st_we) line_store[st_addr] <= st_data;
    rd_data <= line_store[rd_addr];
    ptr     <= ptr_next;
    removed <= removed_next;
    start   <= start_next;
    if (emit) begin
      out_kind    <= e_kind;
      out_byte    <= e_byte;
      erase_count <= e_cnt;
      out_last    <= e_last;
    end
    if (rst) begin
      state        <= ST_IDLE;
      line_length  <= 6'd0;
      session_done <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      state        <= state_next;
      line_length  <= line_length_next;
      session_done <= session_done_next;
      if (emit) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end
endmodule

>>> hdl/line_editor_word_wrap_top.sv
// top level: line editor with word wrap
// One typed byte per input beat. A front end classifies the byte and queues
// it (two entries); the back end keeps the line and gives result beats
// through a one-entry output register. Ctrl-W steps back over trailing
// spaces, then over the word, and gives one erase beat if anything was
// removed. A character that overflows the line starts a back scan of the
// line store to find the last space, then gives the newline and the moved
// characters one by one, set by the single registered read and single
// write of the line store. After Ctrl-D on an empty line every further
// beat is consumed and gives no result.
module line_editor_word_wrap_top #(
  parameter int LINE_WIDTH = 40
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] in_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [7:0] out_byte, [13:8] erase_count, rest zero
  output logic [2:0]  m_tuser,   // [2:0] out_kind
  output logic        m_tlast
);
  import lew_pkg::*;

  cmd_t       cmd;
  logic       cmd_valid, cmd_ready;
  logic [7:0] out_byte;
  logic [5:0] erase_count;

  lew_front u_front (
    .clk, .rst,
    .in_valid(s_tvalid), .in_ready(s_tready), .in_byte(s_tdata),
    .cmd_valid, .cmd_ready, .cmd
  );

  lew_back #(.LINE_WIDTH(LINE_WIDTH)) u_back (
    .clk, .rst,
    .cmd_valid, .cmd_ready, .cmd,
    .out_valid(m_tvalid), .out_ready(m_tready),
    .out_kind(m_tuser), .out_byte, .erase_count, .out_last(m_tlast)
  );

  assign m_tdata = {2'd0, erase_count, out_byte};
endmodule

>>> tb/tb_line_editor_word_wrap_top.sv
// testbench: line editor with word wrap, directed and random typing against a line model
`timescale 1ns / 100ps

module tb_line_editor_word_wrap_top;
  import lew_pkg::*;

  localparam int LW = 40;
  localparam int CYCLE_LIMIT = 900000;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] ch;
    logic [5:0] cnt;
    logic       tail;
  } shown_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;
  logic [2:0]  m_tuser;
  logic        m_tlast;

  // line model state
  logic [7:0] line_buf [0:LW];
  int         line_len = 0;
  bit         ended = 1'b0;

  shown_t screen_q [$];
  int     mismatches = 0;
  int     beats_seen = 0;
  int     keys_sent = 0;
  int     wraps_seen = 0;
  int     cycles = 0;
  bit     rx_quiet = 1'b0;   // receiver stops stalling when set
  bit     tx_quiet = 1'b0;

  line_editor_word_wrap_top #(.LINE_WIDTH(LW)) i_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .m_tuser(m_tuser), .m_tlast(m_tlast)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic shown_t mk(logic [2:0] k, logic [7:0] c, int n);
    shown_t s;
    s.kind = k; s.ch = c; s.cnt = n[5:0]; s.tail = 1'b0;
    return s;
  endfunction

  // work out what the terminal shows for one key, update the line
  task automatic predict_key(input logic [7:0] c);
    shown_t outs [$];
    int rm;
    int start;
    int wl;
    if (ended) return;
    if (c == CH_DEL || c == CH_BS) begin
      if (line_len > 0) begin
        line_len--;
        outs.push_back(mk(K_ERASE, 8'd0, 1));
      end else outs.push_back(mk(K_BELL, 8'd0, 0));
    end else if (c == CH_KILL) begin
      if (line_len > 0) outs.push_back(mk(K_ERASE, 8'd0, line_len));
      line_len = 0;
    end else if (c == CH_WERASE) begin
      rm = 0;
      while (line_len > 0 && line_buf[line_len-1] == CH_SPACE) begin
        line_len--; rm++;
      end
      while (line_len > 0 && line_buf[line_len-1] != CH_SPACE) begin
        line_len--; rm++;
      end
      if (rm > 0) outs.push_back(mk(K_ERASE, 8'd0, rm));
    end else if (c == CH_LF || c == CH_CR) begin
      outs.push_back(mk(K_NEWLINE, 8'd0, 0));
      line_len = 0;
    end else if (c == CH_EOT) begin
      if (line_len == 0) begin
        ended = 1'b1;
        outs.push_back(mk(K_ENDED, 8'd0, 0));
      end
    end else if (c == CH_BEL) begin
      outs.push_back(mk(K_BELL, 8'd0, 0));
    end else if (c >= CH_SPACE && c <= CH_TILDE) begin
      line_buf[line_len] = c;
      line_len++;
      outs.push_back(mk(K_ECHO, c, 0));
      if (line_len > LW) begin
        wraps_seen++;
        start = LW;
        for (int j = LW; j > 0; j--) begin
          if (line_buf[j-1] == CH_SPACE) begin
            start = j;
            break;
          end
        end
        outs.push_back(mk(K_NEWLINE, 8'd0, 0));
        for (int k = start; k < line_len; k++) outs.push_back(mk(K_ECHO, line_buf[k], 0));
        wl = line_len - start;
        for (int k = 0; k < wl; k++) line_buf[k] = line_buf[start + k];
        line_len = wl;
      end
    end else begin
      outs.push_back(mk(K_BELL, 8'd0, 0));
    end
    if (outs.size() > 0) outs[outs.size()-1].tail = 1'b1;
    foreach (outs[i]) screen_q.push_back(outs[i]);
  endtask

  // send one key beat, idling at random unless quiet
  task automatic type_key(input logic [7:0] c);
    while (!tx_quiet && $urandom_range(99) < 34) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= c;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predict_key(c);
    keys_sent++;
  endtask

  // receiver stalls
  always @(posedge clk) begin
    if (rst) m_tready <= 1'b0;
    else m_tready <= rx_quiet ? 1'b1 : ($urandom_range(99) >= 34);
  end

  // compare every result beat with the oldest expectation
  always @(posedge clk) begin
    shown_t got;
    shown_t exp_s;
    if (!rst && m_tvalid && m_tready) begin
      got.kind = m_tuser; got.ch = m_tdata[7:0]; got.cnt = m_tdata[13:8];
      got.tail = m_tlast;
      beats_seen++;
      if (screen_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected beat kind=%0d byte=%h cnt=%0d last=%b",
                                       got.kind, got.ch, got.cnt, got.tail);
      end else begin
        exp_s = screen_q.pop_front();
        if (got !== exp_s || m_tdata[15:14] !== '0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch exp kind=%0d byte=%h cnt=%0d last=%b got kind=%0d byte=%h cnt=%0d last=%b",
                     exp_s.kind, exp_s.ch, exp_s.cnt, exp_s.tail,
                     got.kind, got.ch, got.cnt, got.tail);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout with %0d beats still expected", screen_q.size());
      $display("tb_line_editor_word_wrap_top: done, errors");
      $finish;
    end
  end

  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (screen_q.size() != 0) @(posedge clk);
  endtask

  function automatic logic [7:0] rand_print();
    return ($urandom_range(3) == 0) ? CH_SPACE : 8'($urandom_range(8'h21, 8'h7e));
  endfunction

  // edit keys on short and empty lines
  task automatic test_edit_keys();
    type_key(CH_BS);                // bell on empty line
    type_key(CH_KILL);              // nothing on empty line
    type_key(CH_WERASE);            // nothing on empty line
    type_key(8'h7e); type_key(CH_SPACE); type_key(8'h21);
    type_key(CH_DEL);
    type_key(CH_EOT);               // ignored, line not empty
    type_key(8'h41); type_key(CH_SPACE); type_key(CH_SPACE);
    type_key(CH_WERASE);            // trailing spaces and word
    type_key(CH_KILL);
    type_key(CH_BEL);
    type_key(8'h00); type_key(8'hff); type_key(8'h80); type_key(8'h1f);
    type_key(8'h55); type_key(CH_CR);
    type_key(8'haa); type_key(CH_LF);
  endtask

  // wrap with and without a space in the line
  task automatic test_wrap();
    for (int i = 0; i <= LW; i++) type_key(8'h61 + 8'(i % 26));   // no space: one char moves
    type_key(CH_KILL);
    for (int i = 0; i < LW + 2; i++) type_key((i % 7 == 6) ? CH_SPACE : 8'h30 + 8'(i % 10));
    type_key(CH_WERASE);
    // space at the very end of the line
    for (int i = 0; i < LW - 1; i++) type_key(8'h5a);
    type_key(CH_SPACE); type_key(8'h59);
    type_key(CH_CR);
    // sender holds off until the screen is up to date
    drain();
  endtask

  // random typing: mostly words, some edit keys and noise
  task automatic test_random_typing(input int n);
    int r;
    for (int i = 0; i < n; i++) begin
      if (i == n / 2) tx_quiet = 1'b1;
      if (i == n / 2 + 40) tx_quiet = 1'b0;
      if (i == n / 4) rx_quiet = 1'b1;
      if (i == n / 4 + 40) rx_quiet = 1'b0;
      r = $urandom_range(99);
      if (r < 70) type_key(rand_print());
      else if (r < 76) type_key($urandom_range(1) ? CH_DEL : CH_BS);
      else if (r < 80) type_key(CH_WERASE);
      else if (r < 82) type_key(CH_KILL);
      else if (r < 86) type_key($urandom_range(1) ? CH_CR : CH_LF);
      else if (r < 88) type_key(CH_BEL);
      else if (r < 90) type_key(CH_EOT);   // ends only on an empty line
      else type_key(8'($urandom_range(255)));
      if (ended) break;
    end
  endtask

  // end of session: later keys give nothing
  task automatic test_session_end();
    type_key(CH_KILL);
    type_key(CH_EOT);
    type_key(8'h41); type_key(CH_BEL); type_key(CH_EOT);
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_edit_keys();
    test_wrap();
    test_random_typing(106);
    test_session_end();
    drain();
    repeat (2 * LW + 20) @(posedge clk);
    $display("typed %0d keys, checked %0d result beats, %0d line wraps",
             keys_sent, beats_seen, wraps_seen);
    if (mismatches == 0 && screen_q.size() == 0) begin
      $display("tb_line_editor_word_wrap_top: done, clean");
    end else begin
      $display("%0d mismatches, %0d beats missing", mismatches, screen_q.size());
      $display("tb_line_editor_word_wrap_top: done, errors");
    end
    $finish;
  end

endmodule
